FILE: rtl/sbst_pkg.sv
// Package for the segment/box slab test: shared constants and types.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package sbst_pkg;

   // Default coordinate width (signed fixed point, 16 fraction bits).
   localparam int COORD_BITS = 32;

   // Slab parameter format: signed, 32 fraction bits, 64 bits in total.
   localparam int T_BITS  = 64;
   localparam int T_FRAC  = 32;
   localparam int T_QBITS = T_BITS - 1;

   // Largest parameter magnitude; also stands for an unbounded exit.
   localparam logic signed [T_BITS-1:0] T_SAT = {1'b0, {(T_BITS-1){1'b1}}};
   // Entry parameter clamp of 2.0.
   localparam logic signed [T_BITS-1:0] T_CLAMP = T_BITS'(64'sd2 <<< T_FRAC);
   localparam int TC_BITS = T_FRAC + 2;

   // Divider pipeline depth: operand stage, one stage per quotient bit, sign stage.
   localparam int DIV_LAT = T_QBITS + 2;

   // Depth of the queue between front and back.
   localparam int Q_DEPTH = 2;

   // Per-axis classification produced by the front.
   typedef struct packed {
      logic [2:0] par;    // direction is zero on this axis
      logic [2:0] pmiss;  // parallel axis with start outside the slab
   } sbst_cls_type;

endpackage
`default_nettype wire

FILE: rtl/sbst_if.sv
// Request and response channel interfaces of the slab test block.
// Depends on sbst_pkg for the default coordinate width.
`timescale 1ns / 1ps
`default_nettype none
interface sbst_req_if #(parameter int CB = sbst_pkg::COORD_BITS);
   logic valid;
   logic ready;
   logic signed [CB-1:0] start_x;
   logic signed [CB-1:0] start_y;
   logic signed [CB-1:0] start_z;
   logic signed [CB-1:0] end_x;
   logic signed [CB-1:0] end_y;
   logic signed [CB-1:0] end_z;
   logic signed [CB-1:0] box_min_x;
   logic signed [CB-1:0] box_min_y;
   logic signed [CB-1:0] box_min_z;
   logic signed [CB-1:0] box_max_x;
   logic signed [CB-1:0] box_max_y;
   logic signed [CB-1:0] box_max_z;

   modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                   box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                   input ready);
   modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                 box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                 output ready);
endinterface

interface sbst_rsp_if #(parameter int CB = sbst_pkg::COORD_BITS);
   logic valid;
   logic ready;
   logic hit;
   logic signed [CB-1:0] hit_x;
   logic signed [CB-1:0] hit_y;
   logic signed [CB-1:0] hit_z;

   modport source (output valid, hit, hit_x, hit_y, hit_z, input ready);
   modport sink (input valid, hit, hit_x, hit_y, hit_z, output ready);
endinterface
`default_nettype wire

FILE: rtl/sbst_queue.sv
// Small register queue between the front and the back of the slab test.
// Depends on sbst_pkg for the default depth.
`timescale 1ns / 1ps
`default_nettype none
module sbst_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = sbst_pkg::Q_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == CNT_W'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign rdata = mem_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/sbst_front.sv
// Front of the slab test: accepts requests, forms direction and slab offsets,
// classifies parallel axes. Depends on sbst_pkg and sbst_if.
`timescale 1ns / 1ps
`default_nettype none
module sbst_front #(
   parameter int CB = sbst_pkg::COORD_BITS
) (
   sbst_req_if.sink               req_ch,
   input  logic                   q_full,
   output logic                   q_push,
   output logic [3*(4*CB+3)+$bits(sbst_pkg::sbst_cls_type)-1:0] q_data
);
   localparam int AW  = CB + 1;
   localparam int AXW = 4 * CB + 3;

   logic signed [CB-1:0] s_v [3];
   logic signed [CB-1:0] e_v [3];
   logic signed [CB-1:0] mn_v [3];
   logic signed [CB-1:0] mx_v [3];
   sbst_pkg::sbst_cls_type cls;

   assign s_v[0]  = req_ch.start_x;
   assign s_v[1]  = req_ch.start_y;
   assign s_v[2]  = req_ch.start_z;
   assign e_v[0]  = req_ch.end_x;
   assign e_v[1]  = req_ch.end_y;
   assign e_v[2]  = req_ch.end_z;
   assign mn_v[0] = req_ch.box_min_x;
   assign mn_v[1] = req_ch.box_min_y;
   assign mn_v[2] = req_ch.box_min_z;
   assign mx_v[0] = req_ch.box_max_x;
   assign mx_v[1] = req_ch.box_max_y;
   assign mx_v[2] = req_ch.box_max_z;

   assign req_ch.ready = !q_full;
   assign q_push = req_ch.valid && !q_full;

   for (genvar a = 0; a < 3; a++) begin : g_axis
      logic signed [AW-1:0] s_x, d, n1, n2;
      assign s_x = {s_v[a][CB-1], s_v[a]};
      assign d   = {e_v[a][CB-1], e_v[a]} - s_x;
      assign n1  = {mn_v[a][CB-1], mn_v[a]} - s_x;
      assign n2  = {mx_v[a][CB-1], mx_v[a]} - s_x;
      assign cls.par[a]   = (d == '0);
      assign cls.pmiss[a] = (d == '0) && ((s_v[a] < mn_v[a]) || (s_v[a] > mx_v[a]));
      assign q_data[a*AXW +: AXW] = {n2, n1, d, s_v[a]};
   end

   assign q_data[3*AXW +: $bits(sbst_pkg::sbst_cls_type)] = cls;
endmodule
`default_nettype wire

FILE: rtl/sbst_div.sv
// Pipelined signed divider for slab parameters: one quotient bit per stage,
// 32 fraction bits, saturating. Depends on sbst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sbst_div #(
   parameter int CB = sbst_pkg::COORD_BITS
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [CB:0]                  num,
   input  logic signed [CB:0]                  den,
   output logic signed [sbst_pkg::T_BITS-1:0]  t
);
   localparam int AW = CB + 1;
   localparam int EW = (AW > 31) ? AW : 31;
   localparam int QB = sbst_pkg::T_QBITS;
   localparam int TB = sbst_pkg::T_BITS;
   localparam int TF = sbst_pkg::T_FRAC;

   logic [EW-1:0] an_ff [QB+1];
   logic [AW-1:0] ad_ff [QB+1];
   logic [AW-1:0] r_ff  [QB+1];
   logic [QB-1:0] q_ff  [QB+1];
   logic          neg_ff [QB+1];
   logic          sat_ff [QB+1];
   logic signed [TB-1:0] t_ff;

   logic [AW-1:0] n_mag, d_mag;
   logic [EW-1:0] n_ext, n_hi;

   assign n_mag = num[AW-1] ? AW'(~num + AW'(1)) : num;
   assign d_mag = den[AW-1] ? AW'(~den + AW'(1)) : den;
   assign n_ext = EW'(n_mag);
   assign n_hi  = n_ext >> 31;

   // Operand stage: magnitudes, sign and overflow check.
   always_ff @(posedge clock) begin
      if (en) begin
         an_ff[0]  <= n_ext;
         ad_ff[0]  <= d_mag;
         r_ff[0]   <= n_hi[AW-1:0];
         q_ff[0]   <= '0;
         neg_ff[0] <= num[AW-1] ^ den[AW-1];
         sat_ff[0] <= (n_hi >= EW'(d_mag));
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_stage
      localparam int BI = QB - 1 - k;
      logic          nbit;
      logic [AW:0]   trial, diff;
      logic          ge;
      if (BI >= TF) begin : g_num
         assign nbit = an_ff[k][BI-TF];
      end else begin : g_zero
         assign nbit = 1'b0;
      end
      assign trial = {r_ff[k], nbit};
      assign diff  = trial - {1'b0, ad_ff[k]};
      assign ge    = (trial >= {1'b0, ad_ff[k]});

      always_ff @(posedge clock) begin
         if (en) begin
            an_ff[k+1]  <= an_ff[k];
            ad_ff[k+1]  <= ad_ff[k];
            r_ff[k+1]   <= ge ? diff[AW-1:0] : trial[AW-1:0];
            q_ff[k+1]   <= {q_ff[k][QB-2:0], ge};
            neg_ff[k+1] <= neg_ff[k];
            sat_ff[k+1] <= sat_ff[k];
         end
      end
   end

   logic signed [TB-1:0] m;
   assign m = sat_ff[QB] ? sbst_pkg::T_SAT : {1'b0, q_ff[QB]};

   // Sign stage.
   always_ff @(posedge clock) begin
      if (en) begin
         t_ff <= neg_ff[QB] ? -m : m;
      end
   end

   assign t = t_ff;
endmodule
`default_nettype wire

FILE: rtl/sbst_back.sv
// Back of the slab test: dividers, interval narrowing, entry point and the
// response register. Depends on sbst_pkg, sbst_if and sbst_div.
`timescale 1ns / 1ps
`default_nettype none
module sbst_back #(
   parameter int CB = sbst_pkg::COORD_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic [3*(4*CB+3)+$bits(sbst_pkg::sbst_cls_type)-1:0] q_data,
   input  logic q_empty,
   output logic q_pop,
   sbst_rsp_if.source rsp_ch
);
   localparam int AW  = CB + 1;
   localparam int AXW = 4 * CB + 3;
   localparam int DL  = sbst_pkg::DIV_LAT;
   localparam int TB  = sbst_pkg::T_BITS;
   localparam int TCB = sbst_pkg::TC_BITS;
   localparam int HB  = TCB / 2;
   localparam int PW  = AW + TCB - HB;
   localparam int SW  = AW + TCB;
   localparam int OW  = SW - sbst_pkg::T_FRAC;
   localparam int CW  = $bits(sbst_pkg::sbst_cls_type);

   logic en;
   logic ov_ff;

   assign en    = !ov_ff || rsp_ch.ready;
   assign q_pop = en && !q_empty;

   // Unpack the queue head.
   logic signed [CB-1:0] s_q [3];
   logic signed [AW-1:0] d_q [3];
   logic signed [AW-1:0] n1_q [3];
   logic signed [AW-1:0] n2_q [3];
   sbst_pkg::sbst_cls_type cls_q;
   logic signed [TB-1:0] t1 [3];
   logic signed [TB-1:0] t2 [3];

   assign cls_q = q_data[3*AXW +: CW];

   for (genvar a = 0; a < 3; a++) begin : g_div
      assign s_q[a]  = q_data[a*AXW +: CB];
      assign d_q[a]  = q_data[a*AXW+CB +: AW];
      assign n1_q[a] = q_data[a*AXW+CB+AW +: AW];
      assign n2_q[a] = q_data[a*AXW+CB+2*AW +: AW];
      sbst_div #(.CB(CB)) u_div_min (
         .clock(clock), .en(en), .num(n1_q[a]), .den(d_q[a]), .t(t1[a]));
      sbst_div #(.CB(CB)) u_div_max (
         .clock(clock), .en(en), .num(n2_q[a]), .den(d_q[a]), .t(t2[a]));
   end

   // Side line that travels beside the dividers.
   logic [DL-1:0]        lv_ff;
   logic signed [CB-1:0] ls_ff [DL][3];
   logic signed [AW-1:0] ld_ff [DL][3];
   sbst_pkg::sbst_cls_type lc_ff [DL];

   always_ff @(posedge clock) begin
      if (en) begin
         ls_ff[0] <= s_q;
         ld_ff[0] <= d_q;
         lc_ff[0] <= cls_q;
         for (int k = 1; k < DL; k++) begin
            ls_ff[k] <= ls_ff[k-1];
            ld_ff[k] <= ld_ff[k-1];
            lc_ff[k] <= lc_ff[k-1];
         end
      end
   end

   // Stage A: order each axis pair.
   logic va_ff, vb_ff, vc_ff, vd_ff, ve_ff;
   logic signed [TB-1:0] lo_ff [3], hi_ff [3], lo_in [3], hi_in [3];
   logic signed [CB-1:0] sa_ff [3];
   logic signed [AW-1:0] da_ff [3];
   sbst_pkg::sbst_cls_type ca_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         lo_in[a] = (t1[a] > t2[a]) ? t2[a] : t1[a];
         hi_in[a] = (t1[a] > t2[a]) ? t1[a] : t2[a];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         sa_ff <= ls_ff[DL-1];
         da_ff <= ld_ff[DL-1];
         ca_ff <= lc_ff[DL-1];
      end
   end

   // Stage B: narrow the interval over the non-parallel axes.
   logic signed [TB-1:0] tmin_ff, tmax_ff, tmin_in, tmax_in;
   logic hb_ff;
   logic signed [CB-1:0] sb_ff [3];
   logic signed [AW-1:0] db_ff [3];

   always_comb begin
      tmin_in = '0;
      tmax_in = sbst_pkg::T_SAT;
      for (int a = 0; a < 3; a++) begin
         if (!ca_ff.par[a]) begin
            if (lo_ff[a] > tmin_in) begin
               tmin_in = lo_ff[a];
            end
            if (hi_ff[a] < tmax_in) begin
               tmax_in = hi_ff[a];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tmin_ff <= tmin_in;
         tmax_ff <= tmax_in;
         hb_ff   <= (ca_ff.pmiss == '0);
         sb_ff   <= sa_ff;
         db_ff   <= da_ff;
      end
   end

   // Stage C: empty-interval check, clamp, direction magnitudes.
   logic [TCB-1:0] tc_ff;
   logic hc_ff;
   logic signed [CB-1:0] sc_ff [3];
   logic [AW-1:0] adc_ff [3];
   logic [2:0]    ngc_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         hc_ff <= hb_ff && !(tmin_ff > tmax_ff);
         tc_ff <= (tmin_ff > sbst_pkg::T_CLAMP) ? TCB'(sbst_pkg::T_CLAMP) : tmin_ff[TCB-1:0];
         sc_ff <= sb_ff;
         for (int a = 0; a < 3; a++) begin
            adc_ff[a] <= db_ff[a][AW-1] ? AW'(~db_ff[a] + AW'(1)) : db_ff[a];
            ngc_ff[a] <= db_ff[a][AW-1];
         end
      end
   end

   // Stage D: partial products of |d| * tmin.
   logic [PW-1:0] pl_ff [3], ph_ff [3];
   logic hd_ff;
   logic signed [CB-1:0] sd_ff [3];
   logic [AW-1:0] add_ff [3];
   logic [2:0]    ngd_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 3; a++) begin
            pl_ff[a] <= PW'(adc_ff[a]) * PW'(tc_ff[HB-1:0]);
            ph_ff[a] <= PW'(adc_ff[a]) * PW'(tc_ff[TCB-1:HB]);
         end
         hd_ff  <= hc_ff;
         sd_ff  <= sc_ff;
         add_ff <= adc_ff;
         ngd_ff <= ngc_ff;
      end
   end

   // Stage E: sum the partial products and drop the fraction.
   logic [OW-1:0] off_ff [3];
   logic [SW-1:0] sum_in [3];
   logic he_ff;
   logic signed [CB-1:0] se_ff [3];
   logic [AW-1:0] ade_ff [3];
   logic [2:0]    nge_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sum_in[a] = SW'(pl_ff[a]) + (SW'(ph_ff[a]) << HB);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 3; a++) begin
            off_ff[a] <= sum_in[a][SW-1:sbst_pkg::T_FRAC];
         end
         he_ff  <= hd_ff;
         se_ff  <= sd_ff;
         ade_ff <= add_ff;
         nge_ff <= ngd_ff;
      end
   end

   // Stage F: entry point and bounds check into the response register.
   logic [OW:0] q_in [3];
   logic [2:0]  inb_in;
   logic        hit_in;
   logic        hit_ff;
   logic signed [CB-1:0] hx_ff, hy_ff, hz_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         q_in[a] = nge_ff[a] ? ({{(OW+1-CB){se_ff[a][CB-1]}}, se_ff[a]} - {1'b0, off_ff[a]})
                             : ({{(OW+1-CB){se_ff[a][CB-1]}}, se_ff[a]} + {1'b0, off_ff[a]});
         inb_in[a] = (off_ff[a] <= OW'(ade_ff[a]));
      end
      hit_in = he_ff && (inb_in == 3'b111);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff <= hit_in;
         hx_ff  <= hit_in ? q_in[0][CB-1:0] : '0;
         hy_ff  <= hit_in ? q_in[1][CB-1:0] : '0;
         hz_ff  <= hit_in ? q_in[2][CB-1:0] : '0;
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         lv_ff <= '0;
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else if (en) begin
         lv_ff <= {lv_ff[DL-2:0], q_pop};
         va_ff <= lv_ff[DL-1];
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
         ov_ff <= ve_ff;
      end
   end

   assign rsp_ch.valid = ov_ff;
   assign rsp_ch.hit   = hit_ff;
   assign rsp_ch.hit_x = hx_ff;
   assign rsp_ch.hit_y = hy_ff;
   assign rsp_ch.hit_z = hz_ff;

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !hit_ff |-> hx_ff == '0 && hy_ff == '0 && hz_ff == '0)
      else $error("miss response carries a nonzero point");

   a_last_stage: assert property (@(posedge clock) disable iff (reset)
      en && ve_ff |=> ov_ff)
      else $error("finished item did not reach the response register");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !ov_ff && lv_ff == '0)
      else $error("pipeline not empty after reset");
endmodule
`default_nettype wire

FILE: rtl/segment_box_slab_test_top.sv
// Top level of the segment versus axis-aligned box slab test.
// Depends on sbst_pkg, sbst_if, sbst_front, sbst_queue and sbst_back.
`timescale 1ns / 1ps
`default_nettype none
// The block takes one query per cycle on req_ch while the queue has room
// (segment start and end, box minimum and maximum corners, signed fixed
// point) and returns one response per query on rsp_ch, in order: a hit flag
// and the entry point, zero on a miss. Sustained rate is one query per clock
// cycle while rsp_ch is ready. A request passes through the queue, the
// bit-per-stage divider pipeline that forms the six slab parameters, interval
// narrowing, the two-part entry point multiply and the response register. A
// short queue sits between the front and the pipelined back so that back
// pressure on rsp_ch stalls the back while the front keeps taking requests
// until the queue fills. The parameter COORD_BITS sets the width of every
// coordinate.
module segment_box_slab_test_top #(
   parameter int COORD_BITS = sbst_pkg::COORD_BITS
) (
   input  logic       clock,
   input  logic       reset,
   sbst_req_if.sink   req_ch,
   sbst_rsp_if.source rsp_ch
);
   localparam int QW = 3 * (4 * COORD_BITS + 3) + $bits(sbst_pkg::sbst_cls_type);

   logic          q_push, q_full, q_pop, q_empty;
   logic [QW-1:0] q_wdata, q_rdata;

   // Classify the request and push it into the queue.
   sbst_front #(.CB(COORD_BITS)) u_front (
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_wdata)
   );

   // Hold classified requests while the back is stalled.
   sbst_queue #(.WIDTH(QW), .DEPTH(sbst_pkg::Q_DEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   // Divide, narrow, form the entry point and drive the response.
   sbst_back #(.CB(COORD_BITS)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_data  (q_rdata),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );
endmodule
`default_nettype wire

FILE: dv/sbst_tb_if.sv
// Testbench-side request and response record types for the slab test.
// No dependencies; channel interfaces come from the RTL (sbst_req_if, sbst_rsp_if).
`timescale 1ns / 1ps
package sbst_tb_pkg;
   typedef struct {
      logic signed [31:0] s[3];
      logic signed [31:0] e[3];
      logic signed [31:0] mn[3];
      logic signed [31:0] mx[3];
   } query_type;

   typedef struct {
      logic               hit;
      logic signed [31:0] p[3];
   } answer_type;
endpackage

FILE: dv/testbench.sv
// Testbench for segment_box_slab_test_top: drives segment/box queries, predicts
// each hit flag and entry point, and checks responses in order.
// Depends on sbst_pkg, sbst_if (RTL) and sbst_tb_pkg.
`timescale 1ns / 1ps
module testbench;

   localparam longint T_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint T_TWO = 64'sh2_0000_0000;
   localparam int LIMIT = 2000000;

   logic clock = 0;
   logic reset = 1;
   always #5 clock = ~clock;

   sbst_req_if req_ch();
   sbst_rsp_if rsp_ch();

   segment_box_slab_test_top dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source)
   );

   sbst_tb_pkg::answer_type expected_hits[$];
   int      mismatches = 0;
   bit      failed = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      hold_off_cycles = 0;
   longint  cycle_count = 0;

   // Divide with 32 fraction bits, truncate toward zero, saturate.
   function automatic longint slab_quotient(longint num, longint den);
      logic [63:0] an, ad, ip, r, f, m;
      bit neg;
      neg = (num < 0) != (den < 0);
      an = num < 0 ? -num : num;
      ad = den < 0 ? -den : den;
      ip = an / ad;
      r = an % ad;
      if (ip >= 64'h8000_0000) begin
         m = T_MAX;
      end else begin
         f = 0;
         for (int i = 0; i < 32; i++) begin
            r = r << 1;
            f = f << 1;
            if (r >= ad) begin
               r = r - ad;
               f[0] = 1'b1;
            end
         end
         m = (ip << 32) | f;
      end
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic sbst_tb_pkg::answer_type predict_entry(sbst_tb_pkg::query_type q);
      sbst_tb_pkg::answer_type a;
      longint s[3], e[3], d[3], pt[3];
      longint tmin, tmax, t1, t2, k, mn, mx, lo, hi;
      logic [63:0] tc, ti, tf, ad, off;
      bit hit;
      tmin = 0;
      tmax = T_MAX;
      hit = 1;
      for (int i = 0; i < 3; i++) begin
         s[i] = q.s[i];
         e[i] = q.e[i];
         d[i] = e[i] - s[i];
      end
      for (int i = 0; i < 3; i++) begin
         if (hit) begin
            mn = q.mn[i];
            mx = q.mx[i];
            if (d[i] == 0) begin
               if (s[i] < mn || s[i] > mx) hit = 0;
            end else begin
               t1 = slab_quotient(mn - s[i], d[i]);
               t2 = slab_quotient(mx - s[i], d[i]);
               if (t1 > t2) begin
                  k = t1; t1 = t2; t2 = k;
               end
               if (t1 > tmin) tmin = t1;
               if (t2 < tmax) tmax = t2;
               if (tmin > tmax) hit = 0;
            end
         end
      end
      if (hit) begin
         tc = tmin > T_TWO ? T_TWO : tmin;
         ti = tc >> 32;
         tf = tc & 64'hFFFF_FFFF;
         for (int i = 0; i < 3; i++) begin
            ad = d[i] < 0 ? -d[i] : d[i];
            off = ad * ti + (ad >> 32) * tf + (((ad & 64'hFFFF_FFFF) * tf) >> 32);
            lo = s[i] < e[i] ? s[i] : e[i];
            hi = s[i] < e[i] ? e[i] : s[i];
            pt[i] = d[i] < 0 ? s[i] - longint'(off) : s[i] + longint'(off);
            if (pt[i] < lo || pt[i] > hi) hit = 0;
         end
      end
      a.hit = hit;
      for (int i = 0; i < 3; i++) a.p[i] = hit ? pt[i][31:0] : '0;
      return a;
   endfunction

   // Drive every input known from time zero.
   initial begin
      req_ch.valid = 0;
      {req_ch.start_x, req_ch.start_y, req_ch.start_z} = '0;
      {req_ch.end_x, req_ch.end_y, req_ch.end_z} = '0;
      {req_ch.box_min_x, req_ch.box_min_y, req_ch.box_min_z} = '0;
      {req_ch.box_max_x, req_ch.box_max_y, req_ch.box_max_z} = '0;
      rsp_ch.ready = 0;
   end

   // Idle randomly with valid low, then offer one request and hold until accepted.
   task automatic send_query(sbst_tb_pkg::query_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.start_x <= q.s[0]; req_ch.start_y <= q.s[1]; req_ch.start_z <= q.s[2];
      req_ch.end_x <= q.e[0]; req_ch.end_y <= q.e[1]; req_ch.end_z <= q.e[2];
      req_ch.box_min_x <= q.mn[0]; req_ch.box_min_y <= q.mn[1];
      req_ch.box_min_z <= q.mn[2];
      req_ch.box_max_x <= q.mx[0]; req_ch.box_max_y <= q.mx[1];
      req_ch.box_max_z <= q.mx[2];
      expected_hits.insert(expected_hits.size(), predict_entry(q));
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Drop valid, wait for every outstanding response, then let the pipe drain.
   task automatic drain_responses();
      req_ch.valid <= 0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // Receiver ready: random stalls plus an explicit long hold-off.
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ch.ready <= 0;
      end else begin
         rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each accepted response against the oldest prediction.
   always @(posedge clock) begin
      sbst_tb_pkg::answer_type x;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_hits.size() == 0) begin
            failed = 1;
            mismatches++;
            if (mismatches <= 10) $display("unexpected response hit=%0b", rsp_ch.hit);
         end else begin
            x = expected_hits.pop_front();
            if (rsp_ch.hit !== x.hit || rsp_ch.hit_x !== x.p[0] ||
                rsp_ch.hit_y !== x.p[1] || rsp_ch.hit_z !== x.p[2]) begin
               failed = 1;
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %0b %h %h %h got %0b %h %h %h",
                           x.hit, x.p[0], x.p[1], x.p[2],
                           rsp_ch.hit, rsp_ch.hit_x, rsp_ch.hit_y, rsp_ch.hit_z);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic signed [31:0] any_coord();
      case ($urandom_range(5))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return $urandom_range(8);
         default: return $urandom;
      endcase
   endfunction

   // Mostly boxes a segment can actually reach: small coordinates near each other.
   function automatic sbst_tb_pkg::query_type reachable_query();
      sbst_tb_pkg::query_type q;
      int span;
      logic signed [31:0] a, b;
      span = $urandom_range(3) == 0 ? 32'h7FFF_0000 : (1 << $urandom_range(6, 22));
      for (int i = 0; i < 3; i++) begin
         q.s[i] = $signed($urandom_range(span)) - span / 2;
         q.e[i] = ($urandom_range(7) == 0) ? q.s[i] :
                  $signed($urandom_range(span)) - span / 2;
         a = $signed($urandom_range(span)) - span / 2;
         b = $signed($urandom_range(span)) - span / 2;
         q.mn[i] = ($urandom_range(9) == 0) ? b : (a < b ? a : b);
         q.mx[i] = ($urandom_range(9) == 0) ? a : (a < b ? b : a);
      end
      if ($urandom_range(9) == 0) q.s[$urandom_range(2)] = any_coord();
      return q;
   endfunction

   function automatic sbst_tb_pkg::query_type noise_query();
      sbst_tb_pkg::query_type q;
      for (int i = 0; i < 3; i++) begin
         q.s[i] = any_coord(); q.e[i] = any_coord();
         q.mn[i] = any_coord(); q.mx[i] = any_coord();
      end
      return q;
   endfunction

   function automatic sbst_tb_pkg::query_type make_query(int sv, int ev, int mnv, int mxv);
      sbst_tb_pkg::query_type q;
      for (int i = 0; i < 3; i++) begin
         q.s[i] = sv; q.e[i] = ev; q.mn[i] = mnv; q.mx[i] = mxv;
      end
      return q;
   endfunction

   // Hits, misses, parallel axes, inverted box, extremes, large entry parameter.
   task automatic test_directed();
      sbst_tb_pkg::query_type q;
      send_query(make_query(0, 32'sh0004_0000, 32'sh0001_0000, 32'sh0002_0000));
      send_query(make_query(32'sh0004_0000, 0, 32'sh0001_0000, 32'sh0002_0000));
      q = make_query(0, 32'sh0004_0000, 32'sh0001_0000, 32'sh0002_0000);
      q.e[1] = 0;
      send_query(q);                              // parallel y, start below slab
      q.mn[1] = 32'sh0000_8000;
      send_query(q);                              // parallel y, start below slab
      q.mn[1] = -5; q.mx[1] = -1;
      send_query(q);                              // parallel y, start above slab
      q.mn[1] = 5; q.mx[1] = -5;
      send_query(q);                              // inverted box, parallel axis
      send_query(make_query(0, 32'sh0004_0000, 32'sh0002_0000, 32'sh0001_0000));
      send_query(make_query(0, 10, 20, 30));      // box beyond the end
      send_query(make_query(0, 1, 32'sh7FFF_0000, 32'sh7FFF_FFFF)); // huge tmin
      send_query(make_query(32'sh8000_0000, 32'sh7FFF_FFFF,
                            32'sh8000_0000, 32'sh7FFF_FFFF));
      send_query(make_query(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0));
      send_query(make_query(32'sh8000_0000, 32'sh8000_0000,
                            32'sh8000_0000, 32'sh8000_0000));
      send_query(make_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                            32'sh8000_0000, 32'sh7FFF_FFFF));
      send_query(make_query(-1, -1, -1, -1));
      send_query(make_query(0, 3, 1, 1));         // inexact entry, rounding toward start
      send_query(make_query(0, -3, -1, -1));
      send_query(make_query(-7, 7, -3, 3));       // start outside box, crosses it
      send_query(make_query(0, 0, 0, 0));
      for (int i = 0; i < 4; i++) send_query(noise_query());
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++)
         send_query($urandom_range(4) == 0 ? noise_query() : reachable_query());
   endtask

   // Hold off the receiver long enough to back up the pipe and stall input.
   task automatic test_backpressure();
      hold_off_cycles = 300;
      test_random(150);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_idle_pct = 38; recv_idle_pct = 65;
      test_directed();
      test_random(450);
      drain_responses();                  // sender pauses until all arrive
      send_idle_pct = 65; recv_idle_pct = 38;
      test_random(450);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_backpressure();
      test_random(450);
      drain_responses();
      if (!failed && expected_hits.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
